// ----- design/lcadc_pkg.sv -----
`default_nettype none
package lcadc_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF  = 8;

    // Fixed widths of the accumulator, the reported average, the timeout and the input count
    localparam int SUM_BITS = 32;
    localparam int AVG_BITS = 24;
    localparam int TMO_BITS = 24;
    localparam int CNT_IN_BITS = 8;

    // Request kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_AVG   = 2'd1;
    localparam logic [1:0] KIND_DUMMY = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_ZERO_N  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_GAIN    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_PDN     = 2'd2;

    // Register reset values
    localparam logic [1:0]          GAIN_RST    = 2'd2;
    localparam logic [TMO_BITS-1:0] TIMEOUT_RST = TMO_BITS'(200000);
    localparam logic                PDN_RST     = 1'b0;

    localparam logic [1:0] GAIN_MAX = 2'd2;

    typedef struct packed {
        logic [1:0]             kind;
        logic                   dout_level;
        logic [CNT_IN_BITS-1:0] sample_count;
    } t_in;

    typedef struct packed {
        logic                       sck_level;
        logic                       result_valid;
        logic signed [AVG_BITS-1:0] average_value;
        logic [1:0]                 status;
        logic                       busy_res;
    } t_out;

endpackage
`default_nettype wire

// ----- design/load_cell_adc_serial_reader_unit.sv -----
// Results: a tick item gives its result in the output register in the cycle
//   after the transfer; the tick that closes an averaged read gives its result
//   when the 32-step restoring divider that forms the average is done.
// Throughput: one tick per cycle while results are taken, none while dividing.
// Reset (i_rst_n low, synchronous): link idle, registers at gain 2,
//   timeout 200000 ticks, power-down off; no result pending.
`default_nettype none
module load_cell_adc_serial_reader_unit #(
    parameter int SAMPLE_BITS = lcadc_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = lcadc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // tick channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire lcadc_pkg::t_in                   i_in,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output lcadc_pkg::t_out                       o_out,
    // configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [1:0]                       i_cfg_index,
    input  wire logic [lcadc_pkg::TMO_BITS-1:0]   i_cfg_data
);
    localparam int SB   = lcadc_pkg::SUM_BITS;
    localparam int AB   = lcadc_pkg::AVG_BITS;
    localparam int TB   = lcadc_pkg::TMO_BITS;
    localparam int BC_W = $clog2(SAMPLE_BITS);

    localparam logic signed [SB:0] AVG_MAX = (SB+1)'((64'sd1 <<< (AB - 1)) - 1);
    localparam logic signed [SB:0] AVG_MIN = -(SB+1)'(64'sd1 <<< (AB - 1));

    // Link sequencer phases; each clock and gain phase is one serial-clock half period
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_CLK_HIGH,
        PH_CLK_LOW,
        PH_GAIN_HIGH,
        PH_GAIN_LOW
    } t_phase;

    // configuration
    logic [1:0]            r_gain;
    logic [TB-1:0]         r_timeout;
    logic                  r_pdn;

    // link state
    t_phase                r_phase,   n_phase;
    logic [BC_W-1:0]       r_bits,    n_bits;
    logic [TB-1:0]         r_wait,    n_wait;
    logic [SAMPLE_BITS-1:0] r_shift,  n_shift;
    logic [SB-1:0]         r_sum,     n_sum;
    logic [COUNT_BITS-1:0] r_done,    n_done;
    logic [COUNT_BITS-1:0] r_want,    n_want;
    logic                  r_dummy,   n_dummy;

    // result register and divider handshake
    lcadc_pkg::t_out       r_out;
    logic                  r_out_valid;
    logic                  r_div_busy;

    lcadc_pkg::t_out       w_step_out;
    logic                  w_finish_avg;
    logic                  w_in_xfer;
    logic                  w_start_div;
    logic [1:0]            w_gsel;
    logic [COUNT_BITS-1:0] w_cnt;
    logic signed [SAMPLE_BITS-1:0] w_samp;
    logic [SB-1:0]         w_samp_ext;
    logic                  w_div_done;
    logic signed [SB:0]    w_quot;
    logic signed [AB-1:0]  w_avg_sat;

    assign o_cfg_ready = 1'b1;
    // A new tick is taken unless the divider is running or an untaken result
    // would be overwritten.
    assign o_in_ready  = !r_div_busy && (!r_out_valid || i_out_ready);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_start_div = w_in_xfer && w_finish_avg;

    assign w_gsel     = (r_gain > lcadc_pkg::GAIN_MAX) ? lcadc_pkg::GAIN_MAX : r_gain;
    assign w_cnt      = COUNT_BITS'(i_in.sample_count);
    assign w_samp     = r_shift;
    assign w_samp_ext = SB'(w_samp);

    // One tick of the link sequencer
    always_comb begin
        n_phase      = r_phase;
        n_bits       = r_bits;
        n_wait       = r_wait;
        n_shift      = r_shift;
        n_sum        = r_sum;
        n_done       = r_done;
        n_want       = r_want;
        n_dummy      = r_dummy;
        w_finish_avg = 1'b0;
        w_step_out   = '0;
        w_step_out.sck_level = r_pdn;
        unique case (r_phase)
            PH_WAIT: begin
                if (!i_in.dout_level) begin
                    n_bits  = '0;
                    n_shift = '0;
                    n_phase = PH_CLK_HIGH;
                end else if ({1'b0, r_wait} + 1'b1 >= {1'b0, r_timeout}) begin
                    w_step_out.result_valid = 1'b1;
                    w_step_out.status       = lcadc_pkg::STAT_TIMEOUT;
                    n_phase = PH_IDLE;
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            PH_CLK_HIGH: begin
                // data bit sampled on the high half, MSB first
                w_step_out.sck_level = 1'b1;
                n_shift = {r_shift[SAMPLE_BITS-2:0], i_in.dout_level};
                n_phase = PH_CLK_LOW;
            end
            PH_CLK_LOW: begin
                w_step_out.sck_level = 1'b0;
                if (r_bits >= BC_W'(SAMPLE_BITS - 1)) begin
                    n_bits  = '0;
                    n_phase = PH_GAIN_HIGH;
                end else begin
                    n_bits  = r_bits + 1'b1;
                    n_phase = PH_CLK_HIGH;
                end
            end
            PH_GAIN_HIGH: begin
                w_step_out.sck_level = 1'b1;
                n_phase = PH_GAIN_LOW;
            end
            PH_GAIN_LOW: begin
                w_step_out.sck_level = 1'b0;
                if (r_bits < BC_W'(w_gsel)) begin
                    // more gain-select pulses to go
                    n_bits  = r_bits + 1'b1;
                    n_phase = PH_GAIN_HIGH;
                end else begin
                    n_bits = '0;
                    if (r_dummy) begin
                        w_step_out.result_valid = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_sum  = r_sum + w_samp_ext;
                        n_done = r_done + 1'b1;
                        if (n_done >= r_want) begin
                            // last sample: average is formed by the divider
                            w_finish_avg = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_wait  = '0;
                            n_phase = PH_WAIT;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_in.kind == lcadc_pkg::KIND_AVG) begin
                    if (w_cnt == '0) begin
                        w_step_out.result_valid = 1'b1;
                        w_step_out.status       = lcadc_pkg::STAT_ZERO_N;
                    end else begin
                        n_dummy = 1'b0;
                        n_want  = w_cnt;
                        n_done  = '0;
                        n_sum   = '0;
                        n_wait  = '0;
                        n_shift = '0;
                        n_bits  = '0;
                        n_phase = PH_WAIT;
                    end
                end else if (i_in.kind == lcadc_pkg::KIND_DUMMY) begin
                    n_dummy = 1'b1;
                    n_want  = COUNT_BITS'(1);
                    n_done  = '0;
                    n_sum   = '0;
                    n_wait  = '0;
                    n_shift = '0;
                    n_bits  = '0;
                    n_phase = PH_WAIT;
                end
            end
        endcase
        w_step_out.busy_res = (n_phase != PH_IDLE);
    end

    lcadc_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start_div),
        .i_dividend (n_sum),
        .i_divisor  (r_want),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // clamp the quotient to the signed 24-bit result range
    always_comb begin
        priority if (w_quot > AVG_MAX) begin
            w_avg_sat = AB'(AVG_MAX);
        end else if (w_quot < AVG_MIN) begin
            w_avg_sat = AB'(AVG_MIN);
        end else begin
            w_avg_sat = AB'(w_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= lcadc_pkg::GAIN_RST;
            r_timeout   <= lcadc_pkg::TIMEOUT_RST;
            r_pdn       <= lcadc_pkg::PDN_RST;
            r_phase     <= PH_IDLE;
            r_bits      <= '0;
            r_wait      <= '0;
            r_shift     <= '0;
            r_sum       <= '0;
            r_done      <= '0;
            r_want      <= '0;
            r_dummy     <= 1'b0;
            r_out_valid <= 1'b0;
            r_div_busy  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lcadc_pkg::CFG_GAIN:    r_gain    <= i_cfg_data[1:0];
                    lcadc_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    lcadc_pkg::CFG_PDN:     r_pdn     <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (w_in_xfer) begin
                r_phase <= n_phase;
                r_bits  <= n_bits;
                r_wait  <= n_wait;
                r_shift <= n_shift;
                r_sum   <= n_sum;
                r_done  <= n_done;
                r_want  <= n_want;
                r_dummy <= n_dummy;
            end

            // result register: loaded per tick, or by the divider at the end
            // of an averaged read
            priority if (w_in_xfer && !w_finish_avg) begin
                r_out       <= w_step_out;
                r_out_valid <= 1'b1;
            end else if (w_div_done) begin
                r_out.sck_level     <= 1'b0;
                r_out.result_valid  <= 1'b1;
                r_out.average_value <= w_avg_sat;
                r_out.status        <= lcadc_pkg::STAT_OK;
                r_out.busy_res      <= 1'b0;
                r_out_valid         <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            priority if (w_start_div) begin
                r_div_busy <= 1'b1;
            end else if (w_div_done) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ----- design/lcadc_div.sv -----
`default_nettype none
// Restoring divider: signed sum over an unsigned nonzero count, one quotient
// bit per cycle, truncation toward zero.
module lcadc_div #(
    parameter int COUNT_BITS = lcadc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [lcadc_pkg::SUM_BITS-1:0] i_dividend,
    input  wire logic [COUNT_BITS-1:0]                 i_divisor,
    output logic                                       o_done,
    output logic signed [lcadc_pkg::SUM_BITS:0]        o_quotient
);
    localparam int SB = lcadc_pkg::SUM_BITS;
    localparam int CW = $clog2(SB);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [SB-1:0]         r_quo;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic                  r_neg;

    logic [COUNT_BITS:0]   w_trial;
    logic                  w_ge;
    logic [COUNT_BITS:0]   w_diff;
    logic [SB:0]           w_mag;

    assign w_trial = {r_rem, r_quo[SB-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_mag   = {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_dividend[SB-1];
                r_quo  <= i_dividend[SB-1] ? SB'(-i_dividend) : SB'(i_dividend);
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
                r_quo <= {r_quo[SB-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(SB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(w_mag) : $signed(w_mag);

endmodule
`default_nettype wire

// ----- dv/tb_load_cell_adc_serial_reader_unit.sv -----
`timescale 1ns / 1ps
module tb_load_cell_adc_serial_reader_unit;

    // kind 3 has no meaning on the link; it must act as a plain tick
    localparam logic [1:0] KIND_RSVD = 2'd3;
    localparam longint AVG_HI = (longint'(1) << (lcadc_pkg::AVG_BITS - 1)) - 1;
    localparam longint AVG_LO = -(longint'(1) << (lcadc_pkg::AVG_BITS - 1));
    localparam int SB = lcadc_pkg::SAMPLE_BITS_DEF;
    localparam int TMO_W = lcadc_pkg::TMO_BITS;
    localparam int SUM_W = lcadc_pkg::SUM_BITS;

    typedef enum logic [2:0] {
        LINK_IDLE, LINK_WAIT, LINK_CLK_HI, LINK_CLK_LO, LINK_GAIN_HI, LINK_GAIN_LO
    } t_link_phase;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    lcadc_pkg::t_in     i_in        = '0;
    logic               i_out_ready = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [1:0]         i_cfg_index = lcadc_pkg::CFG_GAIN;
    logic [TMO_W-1:0]   i_cfg_data  = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    lcadc_pkg::t_out    o_out;
    logic               o_cfg_ready;

    load_cell_adc_serial_reader_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ticks waiting to be sent, and the link outputs each sent tick must produce
    lcadc_pkg::t_in  tick_q[$];
    lcadc_pkg::t_out link_out_q[$];
    int   fail_cnt     = 0;
    int   ticks_queued = 0;
    logic no_idle      = 1'b0;

    // Shadow of the link master: registers and sequencing state
    logic [1:0]          cfg_gain  = lcadc_pkg::GAIN_RST;
    logic [TMO_W-1:0]    cfg_tmo   = lcadc_pkg::TIMEOUT_RST;
    logic                cfg_pdn   = lcadc_pkg::PDN_RST;
    t_link_phase         link_ph   = LINK_IDLE;
    logic [4:0]          bit_cnt   = '0;
    logic [TMO_W-1:0]    wait_cnt  = '0;
    logic [SB-1:0]       shift_reg = '0;
    logic [SUM_W-1:0]    sum_acc   = '0;
    logic [7:0]          n_done    = '0;
    logic [7:0]          n_want    = '0;
    logic                dummy_rd  = 1'b0;

    function automatic void start_read(input logic dummy, input logic [7:0] n);
        dummy_rd  = dummy;
        n_want    = n;
        n_done    = '0;
        sum_acc   = '0;
        wait_cnt  = '0;
        shift_reg = '0;
        bit_cnt   = '0;
        link_ph   = LINK_WAIT;
    endfunction

    // One tick through the link master; returns what the block must report for it
    function automatic lcadc_pkg::t_out link_tick(input lcadc_pkg::t_in it);
        lcadc_pkg::t_out r;
        logic [1:0]      gsel;
        longint          quot;
        r           = '0;
        r.sck_level = cfg_pdn;
        gsel        = (cfg_gain > lcadc_pkg::GAIN_MAX) ? lcadc_pkg::GAIN_MAX : cfg_gain;
        case (link_ph)
            LINK_WAIT: begin
                if (!it.dout_level) begin
                    // converter ready; this tick still drives the idle level
                    bit_cnt   = '0;
                    shift_reg = '0;
                    link_ph   = LINK_CLK_HI;
                end else if ({1'b0, wait_cnt} + 25'd1 >= {1'b0, cfg_tmo}) begin
                    // zero timeout lands here on the first check too
                    r.result_valid = 1'b1;
                    r.status       = lcadc_pkg::STAT_TIMEOUT;
                    link_ph        = LINK_IDLE;
                end else begin
                    wait_cnt++;
                end
            end
            LINK_CLK_HI: begin
                r.sck_level = 1'b1;
                shift_reg   = {shift_reg[SB-2:0], it.dout_level};
                link_ph     = LINK_CLK_LO;
            end
            LINK_CLK_LO: begin
                r.sck_level = 1'b0;
                if (bit_cnt >= SB - 1) begin
                    bit_cnt = '0;
                    link_ph = LINK_GAIN_HI;
                end else begin
                    bit_cnt++;
                    link_ph = LINK_CLK_HI;
                end
            end
            LINK_GAIN_HI: begin
                r.sck_level = 1'b1;
                link_ph     = LINK_GAIN_LO;
            end
            LINK_GAIN_LO: begin
                r.sck_level = 1'b0;
                if (bit_cnt < gsel) begin
                    bit_cnt++;
                    link_ph = LINK_GAIN_HI;
                end else begin
                    bit_cnt = '0;
                    if (dummy_rd) begin
                        r.result_valid = 1'b1;
                        link_ph        = LINK_IDLE;
                    end else begin
                        sum_acc = sum_acc + {{(SUM_W-SB){shift_reg[SB-1]}}, shift_reg};
                        n_done++;
                        if (n_done >= n_want) begin
                            quot = (n_want == 0) ? 0 :
                                   longint'(signed'(sum_acc)) / longint'(n_want);
                            if (quot > AVG_HI) quot = AVG_HI;
                            if (quot < AVG_LO) quot = AVG_LO;
                            r.average_value = quot[lcadc_pkg::AVG_BITS-1:0];
                            r.result_valid  = 1'b1;
                            link_ph         = LINK_IDLE;
                        end else begin
                            wait_cnt = '0;
                            link_ph  = LINK_WAIT;
                        end
                    end
                end
            end
            default: begin
                link_ph = LINK_IDLE;
                if (it.kind == lcadc_pkg::KIND_AVG) begin
                    if (it.sample_count == 0) begin
                        r.result_valid = 1'b1;
                        r.status       = lcadc_pkg::STAT_ZERO_N;
                    end else begin
                        start_read(1'b0, it.sample_count);
                    end
                end else if (it.kind == lcadc_pkg::KIND_DUMMY) begin
                    start_read(1'b1, 8'd1);
                end
            end
        endcase
        r.busy_res = (link_ph != LINK_IDLE);
        return r;
    endfunction

    function automatic void check_field(input string fname, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            fail_cnt++;
        end
    endfunction

    // Driver: a tick is predicted at the edge of its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                link_out_q.push_back(link_tick(i_in));
            end
            if (!i_in_valid || o_in_ready) begin
                if (tick_q.size() > 0 && (no_idle || $urandom_range(99) >= 36)) begin
                    i_in       <= tick_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result transfer is matched against the oldest prediction
    always @(posedge i_clk) begin
        lcadc_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (link_out_q.size() == 0) begin
                $error("result transfer with no tick outstanding");
                fail_cnt++;
            end else begin
                want = link_out_q.pop_front();
                check_field("sck_level", want.sck_level, o_out.sck_level);
                check_field("result_valid", want.result_valid, o_out.result_valid);
                check_field("average_value", want.average_value, o_out.average_value);
                check_field("status", want.status, o_out.status);
                check_field("busy_res", want.busy_res, o_out.busy_res);
            end
        end
        i_out_ready <= no_idle || ($urandom_range(99) >= 36);
    end

    // ---- stimulus helpers ----

    function automatic void push_tick(input logic [1:0] kind, input logic dout,
                                      input logic [7:0] cnt);
        lcadc_pkg::t_in it;
        it.kind         = kind;
        it.dout_level   = dout;
        it.sample_count = cnt;
        tick_q.push_back(it);
        ticks_queued++;
    endfunction

    // tick during a read: now and then a request, which the block must ignore
    function automatic void push_busy(input logic dout);
        logic [1:0] kind;
        kind = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : lcadc_pkg::KIND_TICK;
        push_tick(kind, dout, 8'($urandom_range(255)));
    endfunction

    function automatic int eff_tmo();
        return (cfg_tmo == 0) ? 1 : int'(cfg_tmo);
    endfunction

    // high-level waits that still stay short of a timeout
    function automatic int wait_room();
        return (eff_tmo() - 1 > 4) ? 4 : eff_tmo() - 1;
    endfunction

    function automatic logic [SB-1:0] rand_word();
        case ($urandom_range(7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            default: return SB'($urandom);
        endcase
    endfunction

    // one conversion: ready wait, 24 data pulses MSB first, then the gain pulses
    function automatic void push_sample(input logic [SB-1:0] word, input int waits);
        int g;
        g = (cfg_gain > lcadc_pkg::GAIN_MAX) ? lcadc_pkg::GAIN_MAX : cfg_gain;
        repeat (waits) push_busy(1'b1);
        push_busy(1'b0);
        for (int b = SB - 1; b >= 0; b--) begin
            push_busy(word[b]);
            push_busy(1'($urandom_range(1)));
        end
        repeat (2 * (g + 1)) push_busy(1'($urandom_range(1)));
    endfunction

    function automatic void push_read(input logic dummy, input int n);
        push_tick(dummy ? lcadc_pkg::KIND_DUMMY : lcadc_pkg::KIND_AVG,
                  1'($urandom_range(1)),
                  dummy ? 8'($urandom_range(255)) : 8'(n));
        repeat (dummy ? 1 : n) push_sample(rand_word(), $urandom_range(wait_room()));
    endfunction

    // request that dies on a ready timeout, possibly after a good first sample
    function automatic void push_timeout(input logic [7:0] n);
        push_tick(lcadc_pkg::KIND_AVG, 1'($urandom_range(1)), n);
        if (n > 1 && $urandom_range(1)) push_sample(rand_word(), $urandom_range(wait_room()));
        repeat (eff_tmo()) push_busy(1'b1);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [TMO_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            lcadc_pkg::CFG_GAIN:    cfg_gain = val[1:0];
            lcadc_pkg::CFG_TIMEOUT: cfg_tmo  = val;
            lcadc_pkg::CFG_PDN:     cfg_pdn  = val[0];
            default:                ;
        endcase
    endtask

    // hold the sender until every result is back; finish any read left half done
    // (checked on the falling edge, after the driver's updates have settled)
    task automatic settle();
        while (tick_q.size() != 0 || i_in_valid || link_out_q.size() != 0)
            @(negedge i_clk);
        while (link_ph != LINK_IDLE) begin
            repeat (16) push_tick(lcadc_pkg::KIND_TICK, 1'b0, '0);
            while (tick_q.size() != 0 || i_in_valid || link_out_q.size() != 0)
                @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input logic [1:0] g, input logic [TMO_W-1:0] tmo,
                             input logic pdn, input int span);
        int first;
        int sel;
        write_reg(lcadc_pkg::CFG_GAIN, TMO_W'(g));
        write_reg(lcadc_pkg::CFG_TIMEOUT, tmo);
        write_reg(lcadc_pkg::CFG_PDN, TMO_W'(pdn));
        first = ticks_queued;
        while (ticks_queued - first < span) begin
            sel = $urandom_range(99);
            if (sel < 50)
                push_read(1'b0, (sel < 10) ? $urandom_range(3, 6) : $urandom_range(1, 2));
            else if (sel < 63)
                push_read(1'b1, 1);
            else if (sel < 76 && eff_tmo() <= 8)
                push_timeout(8'($urandom_range(1, 255)));
            else if (sel < 84)
                push_tick(lcadc_pkg::KIND_AVG, 1'($urandom_range(1)), 8'd0);
            else
                repeat ($urandom_range(1, 4))
                    push_tick($urandom_range(1) ? lcadc_pkg::KIND_TICK : KIND_RSVD,
                              1'($urandom_range(1)), 8'($urandom_range(255)));
        end
        // broken read: request, then random line activity cut off anywhere
        if ($urandom_range(1)) begin
            push_tick(lcadc_pkg::KIND_AVG, 1'b0, 8'($urandom_range(1, 3)));
            repeat ($urandom_range(1, 40)) push_busy(1'($urandom_range(1)));
        end
        settle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset values: plain ticks, reserved kind, zero count, dummy read
        push_tick(lcadc_pkg::KIND_TICK, 1'b0, 8'h00);
        push_tick(lcadc_pkg::KIND_TICK, 1'b1, 8'hFF);
        push_tick(KIND_RSVD, 1'b1, 8'h55);
        push_tick(lcadc_pkg::KIND_AVG, 1'b1, 8'h00);
        push_read(1'b1, 1);
        settle();

        write_reg(lcadc_pkg::CFG_GAIN, 24'd0);
        write_reg(lcadc_pkg::CFG_TIMEOUT, 24'd3);
        write_reg(lcadc_pkg::CFG_PDN, 24'd1);
        // full-scale positive after the longest wait that avoids a timeout
        push_tick(lcadc_pkg::KIND_AVG, 1'b0, 8'd1);
        push_sample(24'h7FFFFF, 2);
        // most negative plus -1: the halved sum must truncate toward zero
        push_tick(lcadc_pkg::KIND_AVG, 1'b0, 8'd2);
        push_sample(24'h800000, 0);
        push_sample(24'hFFFFFF, 1);
        // largest count, timed out at the first sample
        push_tick(lcadc_pkg::KIND_AVG, 1'b1, 8'hFF);
        repeat (3) push_busy(1'b1);
        // timeout on the second sample: wait count restarts per sample
        push_tick(lcadc_pkg::KIND_AVG, 1'b0, 8'd2);
        push_sample(24'h000001, 0);
        repeat (3) push_busy(1'b1);
        settle();

        // zero timeout behaves as one; gain select 3 saturates
        write_reg(lcadc_pkg::CFG_TIMEOUT, 24'd0);
        write_reg(lcadc_pkg::CFG_GAIN, 24'd3);
        push_tick(lcadc_pkg::KIND_AVG, 1'b0, 8'd1);
        push_busy(1'b1);
        push_tick(lcadc_pkg::KIND_DUMMY, 1'b0, 8'd0);
        push_sample(rand_word(), 0);
        settle();

        // random reads across register settings
        run_phase(2'd1, 24'd4, 1'b0, 10);
        run_phase(2'd0, 24'd1, 1'b1, 10);
        no_idle = 1'b1;
        run_phase(2'd3, 24'hFFFFFF, 1'b0, 10);
        no_idle = 1'b0;
        run_phase(2'd2, 24'd2, 1'b1, 10);
        run_phase(2'd1, 24'd0, 1'b0, 10);
        run_phase(2'd0, 24'd7, 1'b1, 10);

        // results trail a closing tick by the divider latency
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("tb_load_cell_adc_serial_reader_unit OK");
        else
            $display("tb_load_cell_adc_serial_reader_unit NOT OK");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb_load_cell_adc_serial_reader_unit NOT OK");
        $finish;
    end

endmodule
